// ===== design/smr_pkg.sv =====
`default_nettype none
package smr_pkg;
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 56;
    localparam int RLEN_W   = 24;
    localparam int ICNT_W   = 11;
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_LEN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 8'd1;

    typedef struct packed {
        logic                       last;
        logic                       group_end;
        logic [RLEN_W-1:0]          divisor;
    } div_req_t;
endpackage
`default_nettype wire

// ===== design/strided_mean_reduction_core.sv =====
// Mean path for the beat that completes a column: read, accumulate,
// 56-step restoring divide, output register.
// A new sample is taken only once the accumulator memory read-modify-write for the one before,
// and for a sample that completes a column the shared serial divider, has finished with it.
// Output stall holds the input only once a second mean is ready behind a waiting one.
// Reset: counters clear, reduce_len and inner_count return to 1, output empty; sums undefined.
`default_nettype none
module strided_mean_reduction_core
#(
    parameter int INNER_DEPTH = 1024
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [smr_pkg::SAMPLE_W-1:0]   sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [smr_pkg::SAMPLE_W-1:0]        mean,
    output logic                                       group_end,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [smr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [31:0]                           cfg_data
);
    localparam int AW = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;
    localparam int KW = $clog2(INNER_DEPTH + 1);
    localparam int SW = smr_pkg::SUM_W;

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [smr_pkg::RLEN_W-1:0]    rlen_reg;
    logic [smr_pkg::ICNT_W-1:0]    icnt_reg;
    logic [KW-1:0]                 k_reg;
    logic [smr_pkg::RLEN_W-1:0]    j_reg;
    logic signed [SW-1:0]          mem [INNER_DEPTH];
    logic signed [SW-1:0]          rd_data_reg;
    logic signed [SW-1:0]          samp_reg;
    logic signed [SW-1:0]          sum;
    logic [smr_pkg::RLEN_W-1:0]    rl_eff;
    logic [KW-1:0]                 ic_eff;
    logic                          col_last;
    logic                          blk_last;
    logic signed [smr_pkg::SAMPLE_W-1:0] mean_reg;
    logic                          ge_out_reg;
    logic                          out_valid_reg;
    logic                          out_free;
    logic                          out_load;
    logic                          div_done;
    logic signed [smr_pkg::SAMPLE_W-1:0] div_q;
    logic                          div_ge;
    logic                          in_acc;
    smr_pkg::div_req_t             req;

    assign rl_eff = (rlen_reg == '0) ? smr_pkg::RLEN_W'(1) : rlen_reg;
    always_comb
    begin
        if (icnt_reg == '0)
            ic_eff = KW'(1);
        else if ({21'd0, icnt_reg} > 32'(INNER_DEPTH))
            ic_eff = KW'(INNER_DEPTH);
        else
            ic_eff = KW'(icnt_reg);
    end

    assign in_acc    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid && !out_valid_reg;
    assign col_last  = (j_reg == rl_eff - 1'b1);
    assign blk_last  = (k_reg + 1'b1 >= ic_eff);
    assign sum       = (j_reg == '0) ? samp_reg : rd_data_reg + samp_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (((state_reg == ST_DIV) && div_done) || (state_reg == ST_OUT)) && out_free;

    assign req.last      = col_last;
    assign req.group_end = blk_last;
    assign req.divisor   = rl_eff;

    always_ff @(posedge clk)
    begin
        if (in_acc)
            rd_data_reg <= mem[k_reg[AW-1:0]];
        if (state_reg == ST_READ)
            mem[k_reg[AW-1:0]] <= sum;
        if (in_acc)
            samp_reg <= SW'(sample);
    end

    smr_divider u_div
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        ((state_reg == ST_READ) && req.last),
        .dividend     (sum),
        .divisor      (req.divisor),
        .group_end_in (req.group_end),
        .done         (div_done),
        .quotient     (div_q),
        .group_end    (div_ge)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_READ;
            ST_READ: state_next = col_last ? ST_DIV : ST_IDLE;
            ST_DIV:  if (div_done) state_next = out_free ? ST_IDLE : ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rlen_reg      <= smr_pkg::RLEN_W'(1);
            icnt_reg      <= smr_pkg::ICNT_W'(1);
            k_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == smr_pkg::REG_REDUCE_LEN)
                begin
                    rlen_reg <= cfg_data[smr_pkg::RLEN_W-1:0];
                    k_reg    <= '0;
                    j_reg    <= '0;
                end
                else if (cfg_index == smr_pkg::REG_INNER_COUNT)
                begin
                    icnt_reg <= cfg_data[smr_pkg::ICNT_W-1:0];
                    k_reg    <= '0;
                    j_reg    <= '0;
                end
            end
            if (state_reg == ST_READ)
            begin
                if (blk_last)
                begin
                    k_reg <= '0;
                    j_reg <= col_last ? '0 : j_reg + 1'b1;
                end
                else
                    k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            mean_reg   <= div_q;
            ge_out_reg <= div_ge;
        end
    end

    assign out_valid = out_valid_reg;
    assign mean      = mean_reg;
    assign group_end = ge_out_reg;
endmodule
`default_nettype wire

// ===== design/smr_divider.sv =====
`default_nettype none
module smr_divider
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [smr_pkg::SUM_W-1:0]  dividend,
    input  wire logic [smr_pkg::RLEN_W-1:0]        divisor,
    input  wire logic                              group_end_in,
    output logic                                   done,
    output logic signed [smr_pkg::SAMPLE_W-1:0]    quotient,
    output logic                                   group_end
);
    localparam int SW = smr_pkg::SUM_W;
    localparam int CW = $clog2(SW + 1);

    logic [SW-1:0]                 quot_reg;
    logic [SW-1:0]                 quot_next;
    logic [smr_pkg::RLEN_W:0]      rem_reg;
    logic [smr_pkg::RLEN_W:0]      rem_next;
    logic [smr_pkg::RLEN_W-1:0]    dvs_reg;
    logic                          neg_reg;
    logic                          ge_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [smr_pkg::RLEN_W:0]      trial;
    logic [SW-1:0]                 mag;

    assign mag = dividend[SW-1] ? (~dividend + 1'b1) : dividend;

    always_comb
    begin
        trial     = {rem_reg[smr_pkg::RLEN_W-1:0], quot_reg[SW-1]};
        quot_next = {quot_reg[SW-2:0], 1'b0};
        rem_next  = trial;
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next     = trial - {1'b0, dvs_reg};
            quot_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(SW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= mag;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            neg_reg  <= dividend[SW-1];
            ge_reg   <= group_end_in;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    logic [SW-1:0] signed_q;
    assign signed_q  = neg_reg ? (~quot_reg + 1'b1) : quot_reg;
    assign quotient  = signed_q[smr_pkg::SAMPLE_W-1:0];
    assign group_end = ge_reg;
    assign done      = done_reg;
endmodule
`default_nettype wire
